>>> hw/rtl/mpfd_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the page-mode framebuffer drawing block
// no dependencies

package mpfd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CoordW = 8;
  localparam int unsigned OpW    = 3;

  // command codes; the eighth code is unused and answered with ok low
  typedef enum logic [OpW-1:0] {
    OP_WRBYTE    = 3'd0,
    OP_RDBYTE    = 3'd1,
    OP_POINT     = 3'd2,
    OP_READPOINT = 3'd3,
    OP_FILL      = 3'd4,
    OP_HLINE     = 3'd5,
    OP_VLINE     = 3'd6
  } opcode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_FILL,
    ST_LINE_RD,
    ST_LINE_WR,
    ST_DONE
  } state_e;

endpackage

>>> hw/rtl/mono_page_framebuffer_draw.sv
`timescale 1ns / 1ps
// Monochrome page-mode framebuffer with byte, point, fill and line commands.
// After reset the store is swept to zero, one byte per cycle, over its SCREEN_WIDTH
// times ceil(SCREEN_HEIGHT/8) bytes (1024 at the defaults) while in_ready_o stays low.
// Byte and point commands issue the store read in the accept cycle; ST_EXEC then does
// the write, if any, and loads the result. Fill writes the data byte to every
// store byte, one per cycle. A line reads and writes back (ST_LINE_RD, ST_LINE_WR) the
// byte of each on-screen pixel and skips off-screen ones. Fill and line load the result
// in ST_DONE. ST_EXEC and ST_DONE wait until the result register is free. The frame
// store's registered read data and the read-modify-write of each byte set these steps.
// One command is in flight at a time; the result register lets a new command be taken
// while the previous result still waits on out_ready_i. Uses mpfd_pkg and mpfd_store.

module mono_page_framebuffer_draw #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mpfd_pkg::OpW-1:0]      opcode_i,
  input  logic [mpfd_pkg::CoordW-1:0]   x_coord_i,
  input  logic [mpfd_pkg::CoordW-1:0]   y_coord_i,
  input  logic [mpfd_pkg::CoordW-1:0]   end_coord_i,
  input  logic [mpfd_pkg::ByteW-1:0]    data_byte_i,
  input  logic                          pixel_on_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mpfd_pkg::ByteW-1:0]    read_value_o,
  output logic                          ok_o
);

  localparam int unsigned PageCount = (SCREEN_HEIGHT + 7) / 8;
  localparam int unsigned StoreSize = SCREEN_WIDTH * PageCount;
  localparam int unsigned AddrW     = $clog2(StoreSize);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(StoreSize - 1);
  localparam logic [mpfd_pkg::CoordW:0] WidthLim  = (mpfd_pkg::CoordW + 1)'(SCREEN_WIDTH);
  localparam logic [mpfd_pkg::CoordW:0] HeightLim = (mpfd_pkg::CoordW + 1)'(SCREEN_HEIGHT);
  localparam logic [5:0] PageMul = 6'(PageCount);

  mpfd_pkg::state_e  state_q, state_d;
  mpfd_pkg::opcode_e op_q, op_d;
  logic [mpfd_pkg::CoordW-1:0] x_q, x_d, y_q, y_d, hi_q, hi_d, i_q, i_d;
  logic [mpfd_pkg::ByteW-1:0]  data_q, data_d;
  logic                        on_q, on_d;
  logic [AddrW-1:0]            ptr_q, ptr_d;

  logic                        out_valid_q, out_valid_d;
  logic [mpfd_pkg::ByteW-1:0]  rv_q, rv_d;
  logic                        ok_q, ok_d;

  logic                        mem_we, mem_re;
  logic [AddrW-1:0]            mem_waddr, mem_raddr;
  logic [mpfd_pkg::ByteW-1:0]  mem_wdata, mem_rdata;

  logic                        accept, out_free;
  logic [mpfd_pkg::CoordW-1:0] px, py, line_start, line_lo, line_hi;
  logic [15:0]                 in_prod, cur_prod;
  logic [AddrW-1:0]            in_addr, cur_addr;
  logic                        cur_on;
  logic [mpfd_pkg::ByteW-1:0]  mask, modified;

  mpfd_store #(
    .Depth (StoreSize),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_ready_o = (state_q == mpfd_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // pixel under work: lines walk i_q along one axis
  assign px = (op_q == mpfd_pkg::OP_HLINE) ? i_q : x_q;
  assign py = (op_q == mpfd_pkg::OP_VLINE) ? i_q : y_q;

  assign in_prod  = 16'(x_coord_i) * 16'(PageMul) + 16'(y_coord_i[7:3]);
  assign in_addr  = in_prod[AddrW-1:0];
  assign cur_prod = 16'(px) * 16'(PageMul) + 16'(py[7:3]);
  assign cur_addr = cur_prod[AddrW-1:0];
  assign cur_on   = ({1'b0, px} < WidthLim) && ({1'b0, py} < HeightLim);

  assign mask     = mpfd_pkg::ByteW'(1) << py[2:0];
  assign modified = on_q ? (mem_rdata | mask) : (mem_rdata & ~mask);

  assign line_start = (mpfd_pkg::opcode_e'(opcode_i) == mpfd_pkg::OP_HLINE) ?
                      x_coord_i : y_coord_i;
  assign line_lo    = (line_start > end_coord_i) ? end_coord_i : line_start;
  assign line_hi    = (line_start > end_coord_i) ? line_start : end_coord_i;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    x_d         = x_q;
    y_d         = y_q;
    hi_d        = hi_q;
    i_d         = i_q;
    data_d      = data_q;
    on_d        = on_q;
    ptr_d       = ptr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rv_d        = rv_q;
    ok_d        = ok_q;
    mem_we      = 1'b0;
    mem_waddr   = cur_addr;
    mem_wdata   = modified;
    mem_re      = 1'b0;
    mem_raddr   = cur_addr;

    case (state_q)
      mpfd_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = '0;
        ptr_d     = ptr_q + AddrW'(1);
        if (ptr_q == LastAddr) begin
          ptr_d   = '0;
          state_d = mpfd_pkg::ST_IDLE;
        end
      end
      mpfd_pkg::ST_IDLE: begin
        if (accept) begin
          op_d      = mpfd_pkg::opcode_e'(opcode_i);
          x_d       = x_coord_i;
          y_d       = y_coord_i;
          hi_d      = line_hi;
          i_d       = line_lo;
          data_d    = data_byte_i;
          on_d      = pixel_on_i;
          ptr_d     = '0;
          mem_re    = 1'b1;
          mem_raddr = in_addr;
          case (mpfd_pkg::opcode_e'(opcode_i))
            mpfd_pkg::OP_FILL:  state_d = mpfd_pkg::ST_FILL;
            mpfd_pkg::OP_HLINE: state_d = mpfd_pkg::ST_LINE_RD;
            mpfd_pkg::OP_VLINE: state_d = mpfd_pkg::ST_LINE_RD;
            default:            state_d = mpfd_pkg::ST_EXEC;
          endcase
        end
      end
      mpfd_pkg::ST_EXEC: begin
        // read data for the byte arrived; commit only once the result slot is free
        if (out_free) begin
          out_valid_d = 1'b1;
          rv_d        = '0;
          ok_d        = 1'b0;
          state_d     = mpfd_pkg::ST_IDLE;
          case (op_q)
            mpfd_pkg::OP_WRBYTE: begin
              mem_we    = cur_on;
              mem_wdata = data_q;
              ok_d      = cur_on;
            end
            mpfd_pkg::OP_RDBYTE: begin
              rv_d = cur_on ? mem_rdata : '0;
              ok_d = cur_on;
            end
            mpfd_pkg::OP_POINT: begin
              mem_we = cur_on;
              ok_d   = cur_on;
            end
            mpfd_pkg::OP_READPOINT: begin
              rv_d = cur_on ? mpfd_pkg::ByteW'(mem_rdata[py[2:0]]) : '0;
              ok_d = cur_on;
            end
            default: begin
              ok_d = 1'b0;
            end
          endcase
        end
      end
      mpfd_pkg::ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = data_q;
        ptr_d     = ptr_q + AddrW'(1);
        if (ptr_q == LastAddr) begin
          ptr_d   = '0;
          state_d = mpfd_pkg::ST_DONE;
        end
      end
      mpfd_pkg::ST_LINE_RD: begin
        if (cur_on) begin
          mem_re  = 1'b1;
          state_d = mpfd_pkg::ST_LINE_WR;
        end else if (i_q == hi_q) begin
          state_d = mpfd_pkg::ST_DONE;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      mpfd_pkg::ST_LINE_WR: begin
        mem_we = 1'b1;
        if (i_q == hi_q) begin
          state_d = mpfd_pkg::ST_DONE;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = mpfd_pkg::ST_LINE_RD;
        end
      end
      mpfd_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          rv_d        = '0;
          ok_d        = 1'b1;
          state_d     = mpfd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mpfd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mpfd_pkg::ST_CLEAR;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    x_q    <= x_d;
    y_q    <= y_d;
    hi_q   <= hi_d;
    i_q    <= i_d;
    data_q <= data_d;
    on_q   <= on_d;
    rv_q   <= rv_d;
    ok_q   <= ok_d;
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = rv_q;
  assign ok_o         = ok_q;

  // the store is never written while waiting for a command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mpfd_pkg::ST_IDLE) |-> !mem_we)
    else $error("store write while idle");

  // a nonzero read value only comes with a completed access
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ok_o || (read_value_o == '0)))
    else $error("read value without ok");

  // one command in flight: a transfer closes the input until its result is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("second command taken while one is in flight");

  // a result is loaded only when the previous one was taken or none was pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(rv_q) && $stable(ok_q)))
    else $error("pending result overwritten");

endmodule

>>> hw/rtl/mpfd_store.sv
`timescale 1ns / 1ps
// frame store: one write port, one read port with registered read data
// standalone, uses mpfd_pkg for the byte width

module mpfd_store #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [mpfd_pkg::ByteW-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic [mpfd_pkg::ByteW-1:0] rdata_o
);

  logic [mpfd_pkg::ByteW-1:0] mem_q [Depth];
  logic [mpfd_pkg::ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// testbench for mono_page_framebuffer_draw: directed table then random commands,
// each result checked against a fixed answer or a local copy of the frame store
// depends on mpfd_pkg and the block's rtl

module tb;

  localparam int unsigned SCR_W    = 128;
  localparam int unsigned SCR_H    = 64;
  localparam int unsigned PAGES    = (SCR_H + 7) / 8;
  localparam int unsigned FB_BYTES = SCR_W * PAGES;
  localparam int unsigned N_DIR    = 25;
  localparam int unsigned N_RAND   = 1080;
  localparam int unsigned HOLD_LEN = 200;
  localparam logic [mpfd_pkg::OpW-1:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic [mpfd_pkg::OpW-1:0]    op;
    logic [mpfd_pkg::CoordW-1:0] x;
    logic [mpfd_pkg::CoordW-1:0] y;
    logic [mpfd_pkg::CoordW-1:0] e;
    logic [mpfd_pkg::ByteW-1:0]  d;
    logic                        on;
  } draw_cmd_t;

  typedef struct packed {
    logic [mpfd_pkg::ByteW-1:0] rv;
    logic                       ok;
  } draw_res_t;

  typedef struct packed {
    draw_cmd_t cmd;
    logic      fixed;
    draw_res_t want;
  } dir_row_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [mpfd_pkg::OpW-1:0]    opcode_i;
  logic [mpfd_pkg::CoordW-1:0] x_coord_i;
  logic [mpfd_pkg::CoordW-1:0] y_coord_i;
  logic [mpfd_pkg::CoordW-1:0] end_coord_i;
  logic [mpfd_pkg::ByteW-1:0]  data_byte_i;
  logic                        pixel_on_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [mpfd_pkg::ByteW-1:0]  read_value_o;
  logic                        ok_o;

  logic [mpfd_pkg::ByteW-1:0] fb_mirror [FB_BYTES];
  draw_res_t        pending_res_q [$];
  int               mismatches;
  int               results_seen;
  int               op_seen [8];
  bit               calm;
  bit               hold_req;

  // hand-checked rows carry a fixed answer; the rest go through the mirror
  dir_row_t dir_rows [N_DIR] = '{
    '{'{mpfd_pkg::OP_RDBYTE,    0,   0,   0,   8'h00, 0}, 1, '{8'h00, 1}},
    '{'{mpfd_pkg::OP_READPOINT, 127, 63,  0,   8'h00, 0}, 1, '{8'h00, 1}},
    '{'{mpfd_pkg::OP_WRBYTE,    127, 63,  0,   8'hFF, 0}, 1, '{8'h00, 1}},
    '{'{mpfd_pkg::OP_RDBYTE,    127, 56,  0,   8'h00, 0}, 1, '{8'hFF, 1}},
    '{'{mpfd_pkg::OP_WRBYTE,    128, 0,   0,   8'h55, 1}, 1, '{8'h00, 0}},
    '{'{mpfd_pkg::OP_RDBYTE,    0,   64,  0,   8'h00, 0}, 1, '{8'h00, 0}},
    '{'{mpfd_pkg::OP_POINT,     255, 255, 0,   8'h00, 1}, 1, '{8'h00, 0}},
    '{'{mpfd_pkg::OP_READPOINT, 0,   255, 0,   8'h00, 0}, 1, '{8'h00, 0}},
    '{'{OP_UNUSED,              255, 255, 255, 8'hFF, 1}, 1, '{8'h00, 0}},
    '{'{mpfd_pkg::OP_FILL,      0,   0,   0,   8'hA5, 0}, 1, '{8'h00, 1}},
    '{'{mpfd_pkg::OP_RDBYTE,    5,   17,  0,   8'h00, 0}, 1, '{8'hA5, 1}},
    '{'{mpfd_pkg::OP_POINT,     0,   0,   0,   8'h00, 1}, 0, '{8'h00, 0}},
    '{'{mpfd_pkg::OP_POINT,     127, 63,  0,   8'h00, 0}, 0, '{8'h00, 0}},
    '{'{mpfd_pkg::OP_READPOINT, 127, 63,  0,   8'h00, 0}, 0, '{8'h00, 0}},
    // line running into coordinate 255, off-screen tail skipped
    '{'{mpfd_pkg::OP_HLINE,     120, 10,  255, 8'h00, 1}, 0, '{8'h00, 0}},
    '{'{mpfd_pkg::OP_HLINE,     255, 63,  0,   8'h00, 0}, 0, '{8'h00, 0}},
    '{'{mpfd_pkg::OP_VLINE,     3,   255, 0,   8'h00, 1}, 0, '{8'h00, 0}},
    '{'{mpfd_pkg::OP_VLINE,     127, 60,  60,  8'h00, 1}, 0, '{8'h00, 0}},
    '{'{mpfd_pkg::OP_VLINE,     200, 0,   63,  8'h00, 1}, 0, '{8'h00, 0}},
    '{'{mpfd_pkg::OP_HLINE,     0,   64,  127, 8'h00, 1}, 0, '{8'h00, 0}},
    '{'{mpfd_pkg::OP_RDBYTE,    3,   0,   0,   8'h00, 0}, 0, '{8'h00, 0}},
    '{'{mpfd_pkg::OP_RDBYTE,    125, 8,   0,   8'h00, 0}, 0, '{8'h00, 0}},
    '{'{mpfd_pkg::OP_FILL,      0,   0,   0,   8'h00, 1}, 1, '{8'h00, 1}},
    '{'{mpfd_pkg::OP_WRBYTE,    64,  32,  0,   8'h5A, 0}, 0, '{8'h00, 0}},
    '{'{mpfd_pkg::OP_READPOINT, 64,  33,  0,   8'h00, 0}, 0, '{8'h00, 0}}
  };

  mono_page_framebuffer_draw DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .x_coord_i   (x_coord_i),
    .y_coord_i   (y_coord_i),
    .end_coord_i (end_coord_i),
    .data_byte_i (data_byte_i),
    .pixel_on_i  (pixel_on_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .read_value_o(read_value_o),
    .ok_o        (ok_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic int fb_index(input int x, input int y);
    return x * PAGES + (y >> 3);
  endfunction

  function automatic void set_pixel(input int x, input int y, input logic on);
    if (x < SCR_W && y < SCR_H) begin
      if (on) fb_mirror[fb_index(x, y)][y % 8] = 1'b1;
      else fb_mirror[fb_index(x, y)][y % 8] = 1'b0;
    end
  endfunction

  // applies one command to the mirror and returns what the block should answer
  function automatic draw_res_t apply_draw(input draw_cmd_t c);
    draw_res_t r;
    logic      hit;
    int        lo;
    int        hi;
    r   = '0;
    hit = (c.x < SCR_W) && (c.y < SCR_H);
    case (c.op)
      mpfd_pkg::OP_WRBYTE: if (hit) begin
        fb_mirror[fb_index(c.x, c.y)] = c.d;
        r.ok = 1'b1;
      end
      mpfd_pkg::OP_RDBYTE: if (hit) begin
        r.rv = fb_mirror[fb_index(c.x, c.y)];
        r.ok = 1'b1;
      end
      mpfd_pkg::OP_POINT: if (hit) begin
        set_pixel(c.x, c.y, c.on);
        r.ok = 1'b1;
      end
      mpfd_pkg::OP_READPOINT: if (hit) begin
        r.rv = {7'd0, fb_mirror[fb_index(c.x, c.y)][c.y % 8]};
        r.ok = 1'b1;
      end
      mpfd_pkg::OP_FILL: begin
        foreach (fb_mirror[i]) fb_mirror[i] = c.d;
        r.ok = 1'b1;
      end
      mpfd_pkg::OP_HLINE, mpfd_pkg::OP_VLINE: begin
        lo = (c.op == mpfd_pkg::OP_HLINE) ? int'(c.x) : int'(c.y);
        hi = c.e;
        if (lo > hi) begin
          lo = c.e;
          hi = (c.op == mpfd_pkg::OP_HLINE) ? int'(c.x) : int'(c.y);
        end
        for (int i = lo; i <= hi; i++) begin
          if (c.op == mpfd_pkg::OP_HLINE) set_pixel(i, c.y, c.on);
          else set_pixel(c.x, i, c.on);
        end
        r.ok = 1'b1;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_cmd(input draw_cmd_t c, input logic fixed, input draw_res_t want);
    draw_res_t pred;
    if (!calm && $urandom_range(0, 99) < 19) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    opcode_i    = c.op;
    x_coord_i   = c.x;
    y_coord_i   = c.y;
    end_coord_i = c.e;
    data_byte_i = c.d;
    pixel_on_i  = c.on;
    in_valid_i  = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pred = apply_draw(c);
    pending_res_q.push_back(fixed ? want : pred);
    op_seen[c.op]++;
    @(negedge clk_i);
  endtask

  function automatic logic [mpfd_pkg::CoordW-1:0] pick_coord(input int lim);
    if ($urandom_range(0, 99) < 85) return mpfd_pkg::CoordW'($urandom_range(0, lim - 1));
    return mpfd_pkg::CoordW'($urandom_range(0, 255));
  endfunction

  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int        r;
    r      = $urandom_range(0, 99);
    c.x    = pick_coord(SCR_W);
    c.y    = pick_coord(SCR_H);
    c.d    = mpfd_pkg::ByteW'($urandom_range(0, 255));
    c.on   = 1'($urandom_range(0, 1));
    c.e    = mpfd_pkg::CoordW'($urandom_range(0, 255));
    if (r < 14) c.op = mpfd_pkg::OP_WRBYTE;
    else if (r < 28) c.op = mpfd_pkg::OP_RDBYTE;
    else if (r < 46) c.op = mpfd_pkg::OP_POINT;
    else if (r < 64) c.op = mpfd_pkg::OP_READPOINT;
    else if (r < 66) c.op = mpfd_pkg::OP_FILL;
    else if (r < 82) begin
      c.op = mpfd_pkg::OP_HLINE;
      c.e  = pick_coord(SCR_W);
    end else if (r < 98) begin
      c.op = mpfd_pkg::OP_VLINE;
      c.e  = pick_coord(SCR_H);
    end else c.op = OP_UNUSED;
    return c;
  endfunction

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req    = 1'b0;
        out_ready_i = 1'b0;
        repeat (HOLD_LEN) @(negedge clk_i);
      end else begin
        out_ready_i = calm || ($urandom_range(0, 99) >= 19);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    draw_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_res_q.size() == 0) begin
        $error("result with nothing expected: read_value %0h ok %0b", read_value_o, ok_o);
        mismatches++;
      end else begin
        want = pending_res_q.pop_front();
        if (read_value_o !== want.rv) begin
          $error("read_value: expected %0h, actual %0h", want.rv, read_value_o);
          mismatches++;
        end
        if (ok_o !== want.ok) begin
          $error("ok: expected %0b, actual %0b", want.ok, ok_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    mismatches   = 0;
    results_seen = 0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    foreach (op_seen[i]) op_seen[i] = 0;
    foreach (fb_mirror[i]) fb_mirror[i] = '0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    opcode_i    = mpfd_pkg::OP_WRBYTE;
    x_coord_i   = '0;
    y_coord_i   = '0;
    end_coord_i = '0;
    data_byte_i = '0;
    pixel_on_i  = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) send_cmd(dir_rows[i].cmd, dir_rows[i].fixed, dir_rows[i].want);

    for (int n = 0; n < N_RAND; n++) begin
      if (n == 300) hold_req = 1'b1;
      calm = (n >= 600 && n < 800);
      send_cmd(random_cmd(), 1'b0, '0);
    end
    calm       = 1'b0;
    in_valid_i = 1'b0;

    while (pending_res_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    $display("commands: wrbyte %0d rdbyte %0d point %0d readpoint %0d fill %0d",
             op_seen[mpfd_pkg::OP_WRBYTE], op_seen[mpfd_pkg::OP_RDBYTE],
             op_seen[mpfd_pkg::OP_POINT], op_seen[mpfd_pkg::OP_READPOINT],
             op_seen[mpfd_pkg::OP_FILL]);
    $display("  hline %0d vline %0d unused %0d, results checked %0d, mismatches %0d",
             op_seen[mpfd_pkg::OP_HLINE], op_seen[mpfd_pkg::OP_VLINE], op_seen[OP_UNUSED],
             results_seen, mismatches);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
